[rtl/bfsa_pkg.sv]
// Shared codes and state types of the best-fit segment allocator.
package bfsa_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_GROW   = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_FIT      = 3'd0,
    ST_GROWN    = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FREED    = 3'd4,
    ST_REFUSED  = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_SCAN,
    S_DECIDE,
    S_MODIFY,
    S_MERGE,
    S_RESP
  } state_e;

endpackage

[rtl/bfsa_cell.sv]
// One segment slot of the rotating segment ring.
module bfsa_cell #(
  parameter int unsigned W = 49
) (
  input  logic         clk_i,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] seg_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      seg_q <= d_i;
    end
  end

  assign q_o = seg_q;

endmodule

[rtl/best_fit_segment_allocator.sv]
// Top level of the best-fit segment allocator: request sequencer and segment ring.
//
// Requests arrive on the slave stream: tuser carries the action, tdata the
// request size, the segment index and the merge-back flag. Every request
// yields exactly one response beat on the master stream: tuser carries the
// status, tdata the segment index, payload offset and heap growth.
// The segment table lives in a ring of cells that rotates one slot per
// cycle while a pass runs; the sequencer sees only the head of the ring
// and writes the tail. A request rounds the size up to alignment, scans
// the table in one pass, decides and loads the response. A changed or
// inserted segment adds a pass; a free or a split adds a merge pass, and
// each neighbor merged adds one more such pass. One request is handled at
// a time; the next is taken in the cycle after the response is registered.
// A response waits in the output register while the receiver stalls; the
// block then takes the next request and holds its response until the first
// beat has left. Reset empties the table and clears the heap end at once.
module best_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned ALIGN_BYTES  = 8,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned SIZE_BITS    = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // req_size, entry_index, merge_back
  input  logic [((SIZE_BITS+$clog2(MAX_SEGMENTS)+1+7)/8)*8-1:0] s_axis_tdata_i,
  // action
  input  logic [bfsa_pkg::ActionW-1:0]        s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // result_index, payload_offset, grow_bytes
  output logic [(($clog2(MAX_SEGMENTS)+2*SIZE_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [bfsa_pkg::StatusW-1:0]        m_axis_tuser_o
);
  import bfsa_pkg::*;

  localparam int unsigned SW     = SIZE_BITS;
  localparam int unsigned IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned XW     = SW + 1;
  localparam int unsigned ALN_L  = $clog2(ALIGN_BYTES);
  localparam int unsigned RSH    = XW + ALN_L;
  localparam int unsigned IN_DW  = ((SW + IDX_W + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_DW = ((IDX_W + 2 * SW + 7) / 8) * 8;
  localparam int unsigned OUT_PAD = OUT_DW - IDX_W - 2 * SW;

  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
  localparam logic [XW:0]   RECIP_C = (XW+1)'(RECIP);
  localparam logic [XW-1:0] ADD_C   = XW'(ALIGN_BYTES - 1);
  localparam logic [XW-1:0] ALN_C   = XW'(ALIGN_BYTES);

  localparam logic [SW+1:0] HDR_X  = (SW+2)'(HEADER_BYTES);
  localparam logic [SW+1:0] ALN_X  = (SW+2)'(ALIGN_BYTES);
  localparam logic [SW+1:0] MASK_X = {2'b00, {SW{1'b1}}};
  localparam logic [CNT_W-1:0] LAST_B = CNT_W'(MAX_SEGMENTS - 1);
  localparam logic [CNT_W-1:0] LAST_A = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(MAX_SEGMENTS);

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
  } seg_t;

  localparam int unsigned SEG_W = $bits(seg_t);

  state_e state_q, state_d;

  seg_t ring_q [MAX_SEGMENTS];
  seg_t tail_d, head, c_q, c_d;
  logic shift;

  logic lag_q, lag_d, merged_q, merged_d, lag_cur, merged_cur;
  logic [CNT_W-1:0] p_q;
  logic pass_last;

  action_e act_q;
  logic [SW-1:0] req_q;
  logic [IDX_W-1:0] idx_q;
  logic back_q, mark_q;
  logic aph_q;
  logic [2*XW:0] prod_q;
  logic [XW-1:0] quo;
  logic [SW:0] asz_q;

  logic [CNT_W-1:0] cnt_q;
  logic [SW-1:0] heap_q;

  logic found_q, inrun_q, tfree_q;
  logic [SW-1:0] best_q, bstart_q, tsize_q, tstart_q, rsstart_q, mstart_q;
  logic [CNT_W-1:0] bi_q, rs_q, mi_q;

  logic mod_en_q, ins_en_q, mrg_en_q;
  logic [CNT_W-1:0] mod_pos_q, ins_pos_q, mrg_pos_q;
  seg_t mod_val_q, ins_val_q;

  status_e rstat_q;
  logic [IDX_W-1:0] rres_q;
  logic [SW-1:0] rpay_q, rgrow_q;

  logic ov_q;
  status_e ostat_q;
  logic [IDX_W-1:0] ores_q;
  logic [SW-1:0] opay_q, ogrow_q;

  logic in_acc, resp_load;
  logic [CNT_W-1:0] idx_c;

  // Decision results.
  logic pl_mod, pl_ins, pl_mrg, pl_cnt_inc, pl_heap_en;
  logic [CNT_W-1:0] pl_mod_pos, pl_ins_pos, pl_mrg_pos;
  seg_t pl_mod_val, pl_ins_val;
  logic [SW-1:0] pl_heap;
  status_e pl_stat;
  logic [CNT_W-1:0] pl_res;
  logic [SW-1:0] pl_pay, pl_grow;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign resp_load = (state_q == S_RESP) && (!ov_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign idx_c = CNT_W'(idx_q);
  assign quo = XW'(prod_q >> RSH);

  assign shift = (state_q == S_SCAN) || (state_q == S_MODIFY) || (state_q == S_MERGE);
  assign pass_last = (state_q == S_MERGE) ? (p_q == LAST_A) : (p_q == LAST_B);
  assign head = ring_q[0];

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_ring
      seg_t nb;
      if (g == MAX_SEGMENTS - 1) begin : g_tail
        assign nb = tail_d;
      end else begin : g_mid
        assign nb = ring_q[g+1];
      end
      bfsa_cell #(.W(SEG_W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift),
        .d_i    (nb),
        .q_o    (ring_q[g])
      );
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_ALIGN;
      S_ALIGN:  if (aph_q) state_d = S_SCAN;
      S_SCAN:   if (pass_last) state_d = S_DECIDE;
      S_DECIDE: begin
        if (pl_mod || pl_ins) state_d = S_MODIFY;
        else if (pl_mrg) state_d = S_MERGE;
        else state_d = S_RESP;
      end
      S_MODIFY: if (pass_last) state_d = mrg_en_q ? S_MERGE : S_RESP;
      S_MERGE:  if (pass_last) state_d = merged_d ? S_MERGE : S_RESP;
      S_RESP:   if (resp_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Ring tail, spare slot and pass mode.
  always_comb begin
    lag_cur    = (p_q == '0) ? (state_q == S_MERGE) : lag_q;
    merged_cur = (p_q == '0) ? 1'b0 : merged_q;
    tail_d   = head;
    c_d      = c_q;
    lag_d    = lag_cur;
    merged_d = merged_cur;
    if (state_q == S_MERGE) begin
      if (lag_cur) begin
        if (p_q == mrg_pos_q + 1'b1 && p_q < cnt_q && head.free) begin
          tail_d.start = c_q.start;
          tail_d.size  = SW'({2'b00, c_q.size} + {2'b00, head.size} + HDR_X);
          tail_d.free  = c_q.free;
          lag_d    = 1'b0;
          merged_d = 1'b1;
        end else begin
          tail_d = c_q;
          c_d    = head;
        end
      end
    end else if (lag_cur) begin
      tail_d = c_q;
      c_d    = head;
    end else begin
      if (state_q == S_SCAN && mark_q && p_q == idx_c) begin
        tail_d.free = 1'b1;
      end
      if (state_q == S_MODIFY && mod_en_q && p_q == mod_pos_q) begin
        tail_d = mod_val_q;
      end
      if (state_q == S_MODIFY && ins_en_q && p_q == ins_pos_q) begin
        tail_d = ins_val_q;
        c_d    = head;
        lag_d  = 1'b1;
      end
    end
  end

  // Request decision after the scan.
  always_comb begin
    logic [SW+1:0] asz_x, d_x, need_x, heap_x;
    logic grow_ok;
    asz_x  = {1'b0, asz_q};
    heap_x = {2'b00, heap_q};
    d_x    = asz_x - {2'b00, tsize_q};
    need_x = HDR_X + asz_x;
    grow_ok = (cnt_q != '0) && (asz_x > {2'b00, tsize_q}) && (asz_x <= MASK_X) &&
              ((heap_x + d_x) <= MASK_X);
    pl_mod = 1'b0;
    pl_ins = 1'b0;
    pl_mrg = 1'b0;
    pl_cnt_inc = 1'b0;
    pl_heap_en = 1'b0;
    pl_mod_pos = bi_q;
    pl_ins_pos = bi_q + 1'b1;
    pl_mrg_pos = bi_q + 1'b1;
    pl_mod_val = '{start: bstart_q, size: asz_q[SW-1:0], free: 1'b0};
    pl_ins_val = '{start: SW'({2'b00, bstart_q} + HDR_X + asz_x),
                   size: SW'({2'b00, best_q} - asz_x - HDR_X), free: 1'b1};
    pl_heap = SW'(heap_x + d_x);
    pl_stat = ST_REFUSED;
    pl_res  = '0;
    pl_pay  = '0;
    pl_grow = '0;
    unique case (act_q)
      ACT_ALLOC: begin
        if (found_q) begin
          pl_mod  = 1'b1;
          pl_stat = ST_FIT;
          pl_res  = bi_q;
          pl_pay  = SW'({2'b00, bstart_q} + HDR_X);
          if (cnt_q < FULL_C && {2'b00, best_q} >= ALN_X + asz_x + HDR_X) begin
            pl_ins = 1'b1;
            pl_mrg = 1'b1;
            pl_cnt_inc = 1'b1;
          end else begin
            pl_mod_val = '{start: bstart_q, size: best_q, free: 1'b0};
          end
        end else if (tfree_q && grow_ok) begin
          pl_mod     = 1'b1;
          pl_mod_pos = cnt_q - 1'b1;
          pl_mod_val = '{start: tstart_q, size: asz_q[SW-1:0], free: 1'b0};
          pl_heap_en = 1'b1;
          pl_stat = ST_GROWN;
          pl_res  = cnt_q - 1'b1;
          pl_pay  = SW'({2'b00, tstart_q} + HDR_X);
          pl_grow = SW'(d_x);
        end else begin
          pl_stat = ST_NOFIT;
        end
      end
      ACT_APPEND: begin
        if (cnt_q >= FULL_C) begin
          pl_stat = ST_FULL;
        end else if (asz_x > MASK_X || heap_x + need_x > MASK_X) begin
          pl_stat = ST_REFUSED;
        end else begin
          pl_ins     = 1'b1;
          pl_ins_pos = cnt_q;
          pl_ins_val = '{start: heap_q, size: asz_q[SW-1:0], free: 1'b0};
          pl_cnt_inc = 1'b1;
          pl_heap_en = 1'b1;
          pl_heap    = SW'(heap_x + need_x);
          pl_stat = ST_APPENDED;
          pl_res  = cnt_q;
          pl_pay  = SW'(heap_x + HDR_X);
          pl_grow = SW'(need_x);
        end
      end
      ACT_FREE: begin
        if (idx_c < cnt_q) begin
          pl_mrg     = 1'b1;
          pl_mrg_pos = mi_q;
          pl_stat = ST_FREED;
          pl_res  = mi_q;
          pl_pay  = SW'({2'b00, mstart_q} + HDR_X);
        end
      end
      ACT_GROW: begin
        if (idx_c < cnt_q && idx_c + 1'b1 == cnt_q) begin
          pl_mod     = 1'b1;
          pl_mod_pos = idx_c;
          if (grow_ok) begin
            pl_mod_val = '{start: tstart_q, size: asz_q[SW-1:0], free: 1'b0};
            pl_heap_en = 1'b1;
            pl_stat = ST_GROWN;
            pl_res  = idx_c;
            pl_pay  = SW'({2'b00, tstart_q} + HDR_X);
            pl_grow = SW'(d_x);
          end else begin
            pl_mod_val = '{start: tstart_q, size: tsize_q, free: 1'b0};
          end
        end
      end
      default: pl_stat = ST_REFUSED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      heap_q   <= '0;
      ov_q     <= 1'b0;
      p_q      <= '0;
      lag_q    <= 1'b0;
      merged_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) begin
        p_q      <= pass_last ? '0 : p_q + 1'b1;
        lag_q    <= lag_d;
        merged_q <= merged_d;
      end
      if (state_q == S_MERGE && merged_d && !merged_cur) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (state_q == S_DECIDE) begin
        if (pl_cnt_inc) cnt_q <= cnt_q + 1'b1;
        if (pl_heap_en) heap_q <= pl_heap;
      end
      if (resp_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      c_q <= c_d;
    end
    if (in_acc) begin
      act_q   <= action_e'(s_axis_tuser_i);
      req_q   <= s_axis_tdata_i[SW-1:0];
      idx_q   <= s_axis_tdata_i[SW+IDX_W-1:SW];
      back_q  <= s_axis_tdata_i[SW+IDX_W];
      mark_q  <= (action_e'(s_axis_tuser_i) == ACT_FREE) &&
                 (CNT_W'(s_axis_tdata_i[SW+IDX_W-1:SW]) < cnt_q);
      aph_q   <= 1'b0;
      found_q <= 1'b0;
      inrun_q <= 1'b0;
      tfree_q <= 1'b0;
    end
    if (state_q == S_ALIGN) begin
      if (!aph_q) begin
        prod_q <= (2*XW+1)'({1'b0, req_q} + ADD_C) * (2*XW+1)'(RECIP_C);
        aph_q  <= 1'b1;
      end else begin
        asz_q <= quo * ALN_C;
      end
    end
    if (state_q == S_SCAN && p_q < cnt_q) begin
      if (head.free && {1'b0, head.size} >= asz_q && (!found_q || head.size < best_q)) begin
        found_q  <= 1'b1;
        best_q   <= head.size;
        bi_q     <= p_q;
        bstart_q <= head.start;
      end
      if (p_q == cnt_q - 1'b1) begin
        tsize_q  <= head.size;
        tstart_q <= head.start;
        tfree_q  <= head.free;
      end
      if (p_q < idx_c) begin
        if (head.free) begin
          if (!inrun_q) begin
            rs_q      <= p_q;
            rsstart_q <= head.start;
            inrun_q   <= 1'b1;
          end
        end else begin
          inrun_q <= 1'b0;
        end
      end
      if (p_q == idx_c) begin
        if (back_q && inrun_q) begin
          mi_q     <= rs_q;
          mstart_q <= rsstart_q;
        end else begin
          mi_q     <= p_q;
          mstart_q <= head.start;
        end
      end
    end
    if (state_q == S_DECIDE) begin
      mod_en_q  <= pl_mod;
      ins_en_q  <= pl_ins;
      mrg_en_q  <= pl_mrg;
      mod_pos_q <= pl_mod_pos;
      ins_pos_q <= pl_ins_pos;
      mrg_pos_q <= pl_mrg_pos;
      mod_val_q <= pl_mod_val;
      ins_val_q <= pl_ins_val;
      rstat_q   <= pl_stat;
      rres_q    <= IDX_W'(pl_res);
      rpay_q    <= pl_pay;
      rgrow_q   <= pl_grow;
    end
    if (resp_load) begin
      ostat_q <= rstat_q;
      ores_q  <= rres_q;
      opay_q  <= rpay_q;
      ogrow_q <= rgrow_q;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = ostat_q;
  generate
    if (OUT_PAD > 0) begin : g_pad
      assign m_axis_tdata_o = {{OUT_PAD{1'b0}}, ogrow_q, opay_q, ores_q};
    end else begin : g_nopad
      assign m_axis_tdata_o = {ogrow_q, opay_q, ores_q};
    end
  endgenerate

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_C) else $error("segment count above table size");
  a_scan_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |=> cnt_q == $past(cnt_q)) else $error("count changed in scan");
  a_heap_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q >= $past(heap_q)) else $error("heap end moved back");
  a_resp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= ST_FULL) else $error("bad status code");
`endif

endmodule

[tb/tb_best_fit_segment_allocator.sv]
// Testbench for the best-fit segment allocator: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_best_fit_segment_allocator;
  import bfsa_pkg::*;

  localparam int unsigned NumSegs   = 64;
  localparam int unsigned AlignB    = 8;
  localparam int unsigned HeaderB   = 32;
  localparam longint      SizeMask  = 64'hFF_FFFF;
  localparam int unsigned NumRandom = 1500;
  localparam longint      CycleCap  = 3000000;

  typedef struct {
    action_e     act;
    logic [23:0] size;
    logic [5:0]  idx;
    logic        back;
  } request_t;

  typedef struct {
    status_e     status;
    logic [5:0]  idx;
    logic [23:0] offset;
    logic [23:0] grow;
  } response_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [31:0] s_data;
  logic [1:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [55:0] m_data;
  logic [2:0]  m_user;

  best_fit_segment_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  request_t  request_queue[$];
  response_t expected_responses[$];
  request_t  cur_req;
  int        errors;
  int        accepted_reqs;
  int        checked_resps;
  longint    cycles;
  bit        send_burst;
  bit        recv_burst;
  int        send_wait;
  int        recv_wait;

  logic [23:0] seg_base[NumSegs];
  logic [23:0] seg_len[NumSegs];
  bit          seg_open[NumSegs];
  int          seg_count;
  longint      heap_top;

  function automatic longint round_up(logic [23:0] v);
    return ((longint'(v) + AlignB - 1) / AlignB) * AlignB;
  endfunction

  task automatic remove_seg(int i);
    for (int k = i; k + 1 < seg_count; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k]  = seg_len[k+1];
      seg_open[k] = seg_open[k+1];
    end
    seg_count--;
  endtask

  task automatic insert_seg(int i, longint base, longint len, bit open);
    for (int k = seg_count; k > i; k--) begin
      seg_base[k] = seg_base[k-1];
      seg_len[k]  = seg_len[k-1];
      seg_open[k] = seg_open[k-1];
    end
    seg_base[i] = base[23:0];
    seg_len[i]  = len[23:0];
    seg_open[i] = open;
    seg_count++;
  endtask

  task automatic coalesce(inout int i, input bit back);
    if (back)
      while (i > 0 && seg_open[i-1]) i--;
    while (i + 1 < seg_count && seg_open[i+1]) begin
      seg_len[i] = 24'((longint'(seg_len[i]) + seg_len[i+1] + HeaderB) & SizeMask);
      remove_seg(i + 1);
    end
  endtask

  task automatic extend_tail(input longint asz, output bit ok, output longint added);
    int     t;
    longint d;
    ok    = 0;
    added = 0;
    if (seg_count == 0) return;
    t = seg_count - 1;
    if (asz <= seg_len[t] || asz > SizeMask) return;
    d = asz - seg_len[t];
    if (heap_top + d > SizeMask) return;
    heap_top   += d;
    seg_len[t]  = asz[23:0];
    seg_open[t] = 0;
    added       = d;
    ok          = 1;
  endtask

  task automatic predict_allocation(input request_t r);
    response_t rsp;
    longint    asz;
    longint    best;
    longint    added;
    longint    need;
    int        bi;
    int        mi;
    bit        found;
    bit        ok;
    asz = round_up(r.size);
    rsp = '{ST_REFUSED, '0, '0, '0};
    case (r.act)
      ACT_ALLOC: begin
        best  = 64'h8000_0000;
        bi    = 0;
        found = 0;
        for (int i = 0; i < seg_count; i++)
          if (seg_open[i] && seg_len[i] >= asz && seg_len[i] < best) begin
            best  = seg_len[i];
            bi    = i;
            found = 1;
          end
        if (found) begin
          if (seg_count < NumSegs && seg_len[bi] >= AlignB + asz + HeaderB) begin
            insert_seg(bi + 1, longint'(seg_base[bi]) + HeaderB + asz,
                       seg_len[bi] - asz - HeaderB, 1);
            seg_len[bi] = asz[23:0];
            mi = bi + 1;
            coalesce(mi, 0);
          end
          seg_open[bi] = 0;
          rsp = '{ST_FIT, bi[5:0], seg_base[bi] + 24'(HeaderB), '0};
        end else begin
          ok = 0;
          if (seg_count > 0 && seg_open[seg_count-1]) extend_tail(asz, ok, added);
          if (ok)
            rsp = '{ST_GROWN, 6'(seg_count - 1), seg_base[seg_count-1] + 24'(HeaderB),
                    added[23:0]};
          else
            rsp.status = ST_NOFIT;
        end
      end
      ACT_APPEND: begin
        need = HeaderB + asz;
        if (seg_count >= NumSegs) rsp.status = ST_FULL;
        else if (asz > SizeMask || heap_top + need > SizeMask) rsp.status = ST_REFUSED;
        else begin
          bi = seg_count;
          insert_seg(bi, heap_top, asz, 0);
          heap_top += need;
          rsp = '{ST_APPENDED, bi[5:0], seg_base[bi] + 24'(HeaderB), need[23:0]};
        end
      end
      ACT_FREE: begin
        if (r.idx < seg_count) begin
          seg_open[r.idx] = 1;
          mi = r.idx;
          coalesce(mi, r.back);
          rsp = '{ST_FREED, mi[5:0], seg_base[mi] + 24'(HeaderB), '0};
        end
      end
      default: begin
        if (r.idx < seg_count && r.idx + 1 == seg_count) begin
          extend_tail(asz, ok, added);
          if (ok) rsp = '{ST_GROWN, r.idx, seg_base[r.idx] + 24'(HeaderB), added[23:0]};
          else seg_open[r.idx] = 0;
        end
      end
    endcase
    expected_responses.push_back(rsp);
  endtask

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid   <= 1'b0;
      s_data    <= '0;
      s_user    <= ACT_ALLOC;
      send_wait <= 0;
    end else begin
      if (s_valid && s_ready) begin
        predict_allocation(cur_req);
        accepted_reqs++;
      end
      if (!s_valid || s_ready) begin
        if (send_wait != 0) begin
          s_valid   <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (request_queue.size() > 0) begin
          cur_req   =  request_queue.pop_front();
          s_valid   <= 1'b1;
          s_data    <= {1'b0, cur_req.back, cur_req.idx, cur_req.size};
          s_user    <= cur_req.act;
          send_wait <= send_burst ? 0 : $urandom_range(0, 17);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    response_t exp_rsp;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      recv_wait  <= 0;
      recv_burst <= 1'b0;
      cycles     <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (m_valid && m_ready) begin
        checked_resps++;
        if (expected_responses.size() == 0) begin
          $error("response beat with no request pending, status %0d", m_user);
          errors++;
        end else begin
          exp_rsp = expected_responses.pop_front();
          if (m_user !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, m_user);
            errors++;
          end
          if (m_data[5:0] !== exp_rsp.idx) begin
            $error("result_index: expected %0d, got %0d", exp_rsp.idx, m_data[5:0]);
            errors++;
          end
          if (m_data[29:6] !== exp_rsp.offset) begin
            $error("payload_offset: expected %0d, got %0d", exp_rsp.offset, m_data[29:6]);
            errors++;
          end
          if (m_data[53:30] !== exp_rsp.grow) begin
            $error("grow_bytes: expected %0d, got %0d", exp_rsp.grow, m_data[53:30]);
            errors++;
          end
        end
        if ($urandom_range(0, 99) == 0) recv_burst <= ~recv_burst;
        recv_wait <= recv_burst ? 0 : $urandom_range(0, 17);
        m_ready   <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        m_ready   <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  function automatic request_t make_req(action_e a, logic [23:0] sz, logic [5:0] ix, logic b);
    request_t r;
    r = '{a, sz, ix, b};
    return r;
  endfunction

  initial begin
    request_t r;
    int       pick;
    errors        = 0;
    accepted_reqs = 0;
    checked_resps = 0;
    send_burst    = 0;
    seg_count     = 0;
    heap_top      = 0;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    request_queue.push_back(make_req(ACT_ALLOC,  24'hFF_FFFF, 6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_APPEND, 24'hFF_FFFF, 6'd63, 1'b1));
    request_queue.push_back(make_req(ACT_GROW,   24'd16,      6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_FREE,   24'd0,       6'd63, 1'b1));
    request_queue.push_back(make_req(ACT_APPEND, 24'd0,       6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_APPEND, 24'd100,     6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_APPEND, 24'd1,       6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_APPEND, 24'd200,     6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_FREE,   24'd0,       6'd1,  1'b0));
    request_queue.push_back(make_req(ACT_ALLOC,  24'd40,      6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_ALLOC,  24'd16,      6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_GROW,   24'd400,     6'd4,  1'b0));
    request_queue.push_back(make_req(ACT_GROW,   24'd8,       6'd4,  1'b0));
    request_queue.push_back(make_req(ACT_GROW,   24'd999,     6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_FREE,   24'd0,       6'd4,  1'b1));
    request_queue.push_back(make_req(ACT_ALLOC,  24'h800,     6'd0,  1'b0));
    request_queue.push_back(make_req(ACT_FREE,   24'd0,       6'd0,  1'b1));
    request_queue.push_back(make_req(ACT_FREE,   24'd0,       6'd2,  1'b1));
    request_queue.push_back(make_req(ACT_ALLOC,  24'hFF_FFFF, 6'd0,  1'b1));
    request_queue.push_back(make_req(ACT_ALLOC,  24'h7F_FFF0, 6'd0,  1'b0));

    for (int n = 0; n < NumRandom; n++) begin
      while (request_queue.size() > 0) @(posedge clk_i);
      if (n == NumRandom / 2)
        while (expected_responses.size() > 0 || s_valid) @(posedge clk_i);
      if (n % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (seg_count > 56) pick = (pick < 50) ? 60 : pick;
      if (pick < 30) r.act = ACT_ALLOC;
      else if (pick < 55) r.act = ACT_APPEND;
      else if (pick < 85) r.act = ACT_FREE;
      else r.act = ACT_GROW;
      r.size = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 4095))
                                           : 24'($urandom_range(0, 600));
      if (seg_count > 0 && $urandom_range(0, 4) != 0)
        r.idx = (r.act == ACT_GROW && $urandom_range(0, 1) == 1) ? 6'(seg_count - 1)
                                                                : 6'($urandom_range(0, seg_count - 1));
      else
        r.idx = 6'($urandom_range(0, 63));
      r.back = 1'($urandom_range(0, 1));
      request_queue.push_back(r);
    end

    while (request_queue.size() > 0 || s_valid || expected_responses.size() > 0)
      @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    $display("Ran %0d requests of all four actions with random stalls on both streams.",
             accepted_reqs);
    $display("Checked %0d response beats; %0d segments live at the end.", checked_resps,
             seg_count);
    if (errors == 0 && expected_responses.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bfsa_pkg.sv
rtl/bfsa_cell.sv
rtl/best_fit_segment_allocator.sv
tb/tb_best_fit_segment_allocator.sv
